FILE: design/ecs_pkg.sv
// ----------------------------------------------------------------------------
// Engine crank sequencer package
// Shared types, register indexes, phase and outcome codes, and timer sizing.
// ----------------------------------------------------------------------------
package ecs_pkg;

    // Width of the millisecond elapsed counter (valid range 12 to 32).
    localparam int TIMER_BITS = 16;
    localparam int CFG_W      = 16;
    localparam int SPEED_W    = 16;
    localparam int CFG_IDX_W  = 8;
    localparam int CMP_W      = (TIMER_BITS > CFG_W) ? TIMER_BITS : CFG_W;

    localparam logic [TIMER_BITS-1:0] TIMER_FULL = {TIMER_BITS{1'b1}};

    // Register indexes on the configuration port.
    localparam logic [CFG_IDX_W-1:0] REG_PRIME_TIME  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_CRANK_LIMIT = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_SETTLE_TIME = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_RUN_SPEED   = CFG_IDX_W'(3);

    // Register reset values.
    localparam logic [CFG_W-1:0] PRIME_TIME_RST  = CFG_W'(2000);
    localparam logic [CFG_W-1:0] CRANK_LIMIT_RST = CFG_W'(3500);
    localparam logic [CFG_W-1:0] SETTLE_TIME_RST = CFG_W'(500);
    localparam logic [CFG_W-1:0] RUN_SPEED_RST   = CFG_W'(500);

    // Operation codes of an input beat.
    localparam logic OP_TICK  = 1'b0;
    localparam logic OP_START = 1'b1;

    // Sequence phases.
    localparam logic [1:0] PH_IDLE   = 2'd0;
    localparam logic [1:0] PH_PRIME  = 2'd1;
    localparam logic [1:0] PH_CRANK  = 2'd2;
    localparam logic [1:0] PH_SETTLE = 2'd3;

    // Outcome codes.
    localparam logic [1:0] OUT_NEVER   = 2'd0;
    localparam logic [1:0] OUT_BUSY    = 2'd1;
    localparam logic [1:0] OUT_STARTED = 2'd2;
    localparam logic [1:0] OUT_TIMEOUT = 2'd3;

    typedef struct packed {
        logic [CFG_W-1:0] prime_time_ms;
        logic [CFG_W-1:0] crank_limit_ms;
        logic [CFG_W-1:0] settle_time_ms;
        logic [CFG_W-1:0] run_speed_rpm;
    } cfg_t;

    typedef struct packed {
        logic       ignition_main;
        logic       ignition_aux;
        logic       starter_on;
        logic [1:0] outcome;
    } result_t;

endpackage

FILE: design/ecs_if.sv
// ----------------------------------------------------------------------------
// Engine crank sequencer channel interfaces
// Valid/ready channels for command beats in and relay result beats out.
// ----------------------------------------------------------------------------
interface ecs_cmd_if;
    logic                       valid;
    logic                       ready;
    logic                       operation;
    logic [ecs_pkg::SPEED_W-1:0] engine_speed;

    modport source (output valid, output operation, output engine_speed, input ready);
    modport sink   (input valid, input operation, input engine_speed, output ready);
endinterface

interface ecs_rsp_if;
    logic       valid;
    logic       ready;
    logic       ignition_main;
    logic       ignition_aux;
    logic       starter_on;
    logic [1:0] outcome;

    modport source (output valid, output ignition_main, output ignition_aux,
                    output starter_on, output outcome, input ready);
    modport sink   (input valid, input ignition_main, input ignition_aux,
                    input starter_on, input outcome, output ready);
endinterface

FILE: design/engine_crank_sequencer_core.sv
// ----------------------------------------------------------------------------
// Engine crank sequencer core
// Start sequence for ignition and starter relays, stepped by millisecond
// ticks that carry an engine speed sample.
// ----------------------------------------------------------------------------
//
//   Channel   Dir   Handshake          Payload
//   cmd       in    valid / ready      operation, engine_speed
//   rsp       out   valid / ready      ignition_main, ignition_aux,
//                                      starter_on, outcome
//   cfg       in    cfg_we only        cfg_index, cfg_wdata
//
// Every command beat produces exactly one result beat, in the cycle after
// it is accepted. The phase update is only compares and a counter
// increment, so a new beat can be taken in every cycle; the one-entry
// result register sets the throughput at one beat per cycle while the sink
// keeps up. cmd.ready is low only while a result waits in the register and
// the sink is not taking it this cycle. Reset puts the sequence in idle with
// the registers at their default timing and no result pending.
//
// A start request moves an idle sequence into the prime phase with both
// ignition relays on. Ticks then count up the prime time, after which the
// second ignition relay drops and the starter runs. During cranking each
// tick compares the engine speed with the run threshold; reaching it stops
// the starter and begins the settle wait, after which both ignitions are on
// again. If the crank limit runs out first, every relay is cut and the
// outcome reports a timeout. Start requests during a sequence do nothing.
// Configuration writes take effect on the next beat.
//
module engine_crank_sequencer_core (
    input  logic                          clk,
    input  logic                          rst_n,
    ecs_cmd_if.sink                       cmd,
    ecs_rsp_if.source                     rsp,
    input  logic                          cfg_we,
    input  logic [ecs_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [ecs_pkg::CFG_W-1:0]     cfg_wdata
);

    ecs_pkg::cfg_t    cfg;
    ecs_pkg::result_t seq_result;
    ecs_pkg::result_t rsp_data;
    logic             can_load;
    logic             cmd_beat;

    // A command beat completes when the result register has room for it.
    assign cmd.ready = can_load;
    assign cmd_beat  = cmd.valid && can_load;

    ecs_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    // Phase state advances on the beat itself; the relay drive it computes
    // for the new state lands in the result register on the same edge.
    ecs_seq u_seq (
        .clk          (clk),
        .rst_n        (rst_n),
        .beat         (cmd_beat),
        .operation    (cmd.operation),
        .engine_speed (cmd.engine_speed),
        .cfg          (cfg),
        .result       (seq_result)
    );

    ecs_out_stage u_out_stage (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (cmd_beat),
        .result   (seq_result),
        .take     (rsp.ready),
        .can_load (can_load),
        .valid    (rsp.valid),
        .data     (rsp_data)
    );

    assign rsp.ignition_main = rsp_data.ignition_main;
    assign rsp.ignition_aux  = rsp_data.ignition_aux;
    assign rsp.starter_on    = rsp_data.starter_on;
    assign rsp.outcome       = rsp_data.outcome;

endmodule

FILE: design/ecs_cfg_regs.sv
// ----------------------------------------------------------------------------
// Engine crank sequencer configuration registers
// Four 16-bit timing and speed registers behind a plain write port.
// ----------------------------------------------------------------------------
module ecs_cfg_regs (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [ecs_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [ecs_pkg::CFG_W-1:0]     cfg_wdata,
    output ecs_pkg::cfg_t                 cfg
);

    ecs_pkg::cfg_t cfg_reg;
    ecs_pkg::cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                ecs_pkg::REG_PRIME_TIME:  cfg_next.prime_time_ms  = cfg_wdata;
                ecs_pkg::REG_CRANK_LIMIT: cfg_next.crank_limit_ms = cfg_wdata;
                ecs_pkg::REG_SETTLE_TIME: cfg_next.settle_time_ms = cfg_wdata;
                ecs_pkg::REG_RUN_SPEED:   cfg_next.run_speed_rpm  = cfg_wdata;
                default:                  cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.prime_time_ms  <= ecs_pkg::PRIME_TIME_RST;
            cfg_reg.crank_limit_ms <= ecs_pkg::CRANK_LIMIT_RST;
            cfg_reg.settle_time_ms <= ecs_pkg::SETTLE_TIME_RST;
            cfg_reg.run_speed_rpm  <= ecs_pkg::RUN_SPEED_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

FILE: design/ecs_seq.sv
// ----------------------------------------------------------------------------
// Engine crank sequencer phase logic
// Phase, elapsed counter and last outcome, updated once per accepted beat.
// ----------------------------------------------------------------------------
module ecs_seq (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        beat,
    input  logic                        operation,
    input  logic [ecs_pkg::SPEED_W-1:0] engine_speed,
    input  ecs_pkg::cfg_t               cfg,
    output ecs_pkg::result_t            result
);

    logic [1:0]                     phase_reg;
    logic [1:0]                     phase_next;
    logic [ecs_pkg::TIMER_BITS-1:0] elapsed_reg;
    logic [ecs_pkg::TIMER_BITS-1:0] elapsed_next;
    logic [1:0]                     last_outcome_reg;
    logic [1:0]                     last_outcome_next;

    logic [ecs_pkg::TIMER_BITS-1:0] elapsed_inc;
    logic [ecs_pkg::CFG_W-1:0]      limit;
    logic                           wait_done;
    logic                           running;

    // Saturating count and the end-of-wait check shared by all three waits.
    assign elapsed_inc = (elapsed_reg == ecs_pkg::TIMER_FULL) ?
                         elapsed_reg : elapsed_reg + 1'b1;

    always_comb
    begin
        case (phase_reg)
            ecs_pkg::PH_PRIME:  limit = cfg.prime_time_ms;
            ecs_pkg::PH_CRANK:  limit = cfg.crank_limit_ms;
            default:            limit = cfg.settle_time_ms;
        endcase
    end

    assign wait_done = (ecs_pkg::CMP_W'(elapsed_inc) >= ecs_pkg::CMP_W'(limit)) ||
                       (elapsed_inc == ecs_pkg::TIMER_FULL);
    assign running   = (engine_speed >= cfg.run_speed_rpm);

    always_comb
    begin
        phase_next        = phase_reg;
        elapsed_next      = elapsed_reg;
        last_outcome_next = last_outcome_reg;
        if (operation == ecs_pkg::OP_START)
        begin
            if (phase_reg == ecs_pkg::PH_IDLE)
            begin
                phase_next   = ecs_pkg::PH_PRIME;
                elapsed_next = '0;
            end
        end
        else
        begin
            case (phase_reg)
                ecs_pkg::PH_PRIME:
                begin
                    elapsed_next = elapsed_inc;
                    if (wait_done)
                    begin
                        phase_next   = ecs_pkg::PH_CRANK;
                        elapsed_next = '0;
                    end
                end
                ecs_pkg::PH_CRANK:
                begin
                    if (running)
                    begin
                        phase_next   = ecs_pkg::PH_SETTLE;
                        elapsed_next = '0;
                    end
                    else if (wait_done)
                    begin
                        phase_next        = ecs_pkg::PH_IDLE;
                        elapsed_next      = '0;
                        last_outcome_next = ecs_pkg::OUT_TIMEOUT;
                    end
                    else
                    begin
                        elapsed_next = elapsed_inc;
                    end
                end
                ecs_pkg::PH_SETTLE:
                begin
                    elapsed_next = elapsed_inc;
                    if (wait_done)
                    begin
                        phase_next        = ecs_pkg::PH_IDLE;
                        elapsed_next      = '0;
                        last_outcome_next = ecs_pkg::OUT_STARTED;
                    end
                end
                default:
                begin
                    phase_next = ecs_pkg::PH_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= ecs_pkg::PH_IDLE;
            elapsed_reg      <= '0;
            last_outcome_reg <= ecs_pkg::OUT_NEVER;
        end
        else if (beat)
        begin
            phase_reg        <= phase_next;
            elapsed_reg      <= elapsed_next;
            last_outcome_reg <= last_outcome_next;
        end
    end

    // Relay drive for the state after this beat.
    always_comb
    begin
        case (phase_next)
            ecs_pkg::PH_PRIME:
                result = '{1'b1, 1'b1, 1'b0, ecs_pkg::OUT_BUSY};
            ecs_pkg::PH_CRANK:
                result = '{1'b1, 1'b0, 1'b1, ecs_pkg::OUT_BUSY};
            ecs_pkg::PH_SETTLE:
                result = '{1'b1, 1'b0, 1'b0, ecs_pkg::OUT_BUSY};
            default:
            begin
                result.ignition_main = (last_outcome_next == ecs_pkg::OUT_STARTED);
                result.ignition_aux  = (last_outcome_next == ecs_pkg::OUT_STARTED);
                result.starter_on    = 1'b0;
                result.outcome       = last_outcome_next;
            end
        endcase
    end

endmodule

FILE: design/ecs_out_stage.sv
// ----------------------------------------------------------------------------
// Engine crank sequencer result stage
// One-entry result register that decouples the input side from the sink.
// ----------------------------------------------------------------------------
module ecs_out_stage (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             load,
    input  ecs_pkg::result_t result,
    input  logic             take,
    output logic             can_load,
    output logic             valid,
    output ecs_pkg::result_t data
);

    logic             valid_reg;
    logic             valid_next;
    ecs_pkg::result_t data_reg;

    assign can_load   = !valid_reg || take;
    assign valid_next = load || (valid_reg && !take);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= result;
        end
    end

    assign valid = valid_reg;
    assign data  = data_reg;

endmodule

FILE: design/ecs_checker.sv
// ----------------------------------------------------------------------------
// Engine crank sequencer port checker
// Port-level checks on relay combinations and beat flow, bound to the core.
// ----------------------------------------------------------------------------
module ecs_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       cmd_valid,
    input logic       cmd_ready,
    input logic       rsp_valid,
    input logic       rsp_ready,
    input logic       ignition_main,
    input logic       ignition_aux,
    input logic       starter_on,
    input logic [1:0] outcome
);

    // The starter only runs with the first ignition on and the second off.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && starter_on |-> ignition_main && !ignition_aux)
        else $error("starter driven with wrong ignition relays");

    // The second ignition is never on without the first, and a sequence
    // that never ran drives no relay.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (!ignition_aux || ignition_main) &&
                      (outcome != ecs_pkg::OUT_NEVER ||
                       (!ignition_main && !starter_on)))
        else $error("relay drive inconsistent with outcome");

    // Every accepted command yields a result on the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && cmd_ready |=> rsp_valid)
        else $error("command beat produced no result");

    // A result held back by the sink blocks further commands.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |-> !cmd_ready)
        else $error("command accepted while a result is stalled");

    // A stalled result stays offered.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(outcome))
        else $error("stalled result dropped or changed");

endmodule

bind engine_crank_sequencer_core ecs_checker u_ecs_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd_valid     (cmd.valid),
    .cmd_ready     (cmd.ready),
    .rsp_valid     (rsp.valid),
    .rsp_ready     (rsp.ready),
    .ignition_main (rsp.ignition_main),
    .ignition_aux  (rsp.ignition_aux),
    .starter_on    (rsp.starter_on),
    .outcome       (rsp.outcome)
);

FILE: dv/engine_crank_sequencer_core_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Engine crank sequencer core testbench
// Drives command beats (millisecond ticks and start requests) and register
// writes into the core, predicts every relay result beat with its own model
// of the start sequence, and checks each result beat against that prediction.
// ----------------------------------------------------------------------------
module engine_crank_sequencer_core_tb;

    // The limit leaves wide room for a healthy run with long stretches of
    // stalls on both sides.
    localparam int unsigned CYCLE_LIMIT = 20_000;

    // Random stimulus is split into phases, each with its own register set.
    localparam int RAND_PHASES     = 15;
    localparam int BEATS_PER_PHASE = 55;

    // Index that maps to no register; writes to it must be dropped.
    localparam logic [ecs_pkg::CFG_IDX_W-1:0] REG_UNMAPPED = '1;

    // Relay pictures that can be read straight off the sequence description.
    localparam ecs_pkg::result_t R_NEVER   = '{1'b0, 1'b0, 1'b0, ecs_pkg::OUT_NEVER};
    localparam ecs_pkg::result_t R_PRIME   = '{1'b1, 1'b1, 1'b0, ecs_pkg::OUT_BUSY};
    localparam ecs_pkg::result_t R_CRANK   = '{1'b1, 1'b0, 1'b1, ecs_pkg::OUT_BUSY};
    localparam ecs_pkg::result_t R_SETTLE  = '{1'b1, 1'b0, 1'b0, ecs_pkg::OUT_BUSY};
    localparam ecs_pkg::result_t R_STARTED = '{1'b1, 1'b1, 1'b0, ecs_pkg::OUT_STARTED};
    localparam ecs_pkg::result_t R_TIMEOUT = '{1'b0, 1'b0, 1'b0, ecs_pkg::OUT_TIMEOUT};

    localparam logic T_OP = ecs_pkg::OP_TICK;
    localparam logic S_OP = ecs_pkg::OP_START;

    typedef enum logic { STEP_CMD, STEP_CFG } step_kind_t;

    // One row of the directed table. Command rows send one beat; register
    // rows wait for the core to go quiet and then write one register. A row
    // with pinned set carries its expected relay picture typed in by hand.
    typedef struct {
        step_kind_t                     kind;
        logic [ecs_pkg::CFG_IDX_W-1:0]  index;
        logic                           op;
        logic [ecs_pkg::CFG_W-1:0]      value;
        bit                             pinned;
        ecs_pkg::result_t               want;
    } dir_row_t;

    localparam int DIR_ROWS = 34;

    dir_row_t dir_steps [DIR_ROWS] = '{
        // Out of reset nothing has run, and ticks in idle change nothing.
        '{STEP_CMD, '0, T_OP, 16'h0000, 1'b1, R_NEVER},
        '{STEP_CMD, '0, T_OP, 16'hFFFF, 1'b1, R_NEVER},
        // A start lights both ignitions; a second start is ignored.
        '{STEP_CMD, '0, S_OP, 16'h0000, 1'b1, R_PRIME},
        '{STEP_CMD, '0, S_OP, 16'hFFFF, 1'b1, R_PRIME},
        // A zero prime time written mid-sequence ends priming on the next
        // tick, and that tick does not look at the speed.
        '{STEP_CFG, ecs_pkg::REG_PRIME_TIME,  T_OP, 16'h0000, 1'b0, R_NEVER},
        '{STEP_CMD, '0, T_OP, 16'h1234, 1'b1, R_CRANK},
        // A zero crank limit gives exactly one sample before the timeout.
        '{STEP_CFG, ecs_pkg::REG_RUN_SPEED,   T_OP, 16'hFFFF, 1'b0, R_NEVER},
        '{STEP_CFG, ecs_pkg::REG_CRANK_LIMIT, T_OP, 16'h0000, 1'b0, R_NEVER},
        '{STEP_CMD, '0, T_OP, 16'hFFFE, 1'b1, R_TIMEOUT},
        // Restart after a timeout, then succeed exactly at the threshold.
        '{STEP_CMD, '0, S_OP, 16'h0000, 1'b1, R_PRIME},
        '{STEP_CMD, '0, T_OP, 16'h0000, 1'b1, R_CRANK},
        '{STEP_CFG, ecs_pkg::REG_CRANK_LIMIT, T_OP, 16'h0003, 1'b0, R_NEVER},
        '{STEP_CFG, ecs_pkg::REG_RUN_SPEED,   T_OP, 16'h8000, 1'b0, R_NEVER},
        '{STEP_CMD, '0, T_OP, 16'h7FFF, 1'b0, R_NEVER},
        '{STEP_CMD, '0, T_OP, 16'h8000, 1'b1, R_SETTLE},
        // A start during settling is ignored; settle time of one ends it.
        '{STEP_CFG, ecs_pkg::REG_SETTLE_TIME, T_OP, 16'h0001, 1'b0, R_NEVER},
        '{STEP_CMD, '0, S_OP, 16'h0000, 1'b1, R_SETTLE},
        '{STEP_CMD, '0, T_OP, 16'h0000, 1'b1, R_STARTED},
        // A write to an index past the register list must be dropped.
        '{STEP_CFG, REG_UNMAPPED,             T_OP, 16'hFFFF, 1'b0, R_NEVER},
        // Zero run speed: any sample counts as running; zero settle time.
        '{STEP_CFG, ecs_pkg::REG_RUN_SPEED,   T_OP, 16'h0000, 1'b0, R_NEVER},
        '{STEP_CFG, ecs_pkg::REG_PRIME_TIME,  T_OP, 16'h0002, 1'b0, R_NEVER},
        '{STEP_CFG, ecs_pkg::REG_SETTLE_TIME, T_OP, 16'h0000, 1'b0, R_NEVER},
        '{STEP_CMD, '0, S_OP, 16'h0000, 1'b1, R_PRIME},
        '{STEP_CMD, '0, T_OP, 16'hFFFF, 1'b0, R_NEVER},
        '{STEP_CMD, '0, T_OP, 16'hFFFF, 1'b0, R_NEVER},
        '{STEP_CMD, '0, T_OP, 16'h0000, 1'b0, R_NEVER},
        '{STEP_CMD, '0, T_OP, 16'h0000, 1'b1, R_STARTED},
        // A short crank that times out after two low samples.
        '{STEP_CFG, ecs_pkg::REG_RUN_SPEED,   T_OP, 16'h0007, 1'b0, R_NEVER},
        '{STEP_CFG, ecs_pkg::REG_CRANK_LIMIT, T_OP, 16'h0002, 1'b0, R_NEVER},
        '{STEP_CMD, '0, S_OP, 16'h0000, 1'b0, R_NEVER},
        '{STEP_CMD, '0, T_OP, 16'h0000, 1'b0, R_NEVER},
        '{STEP_CMD, '0, T_OP, 16'h0000, 1'b0, R_NEVER},
        '{STEP_CMD, '0, T_OP, 16'h0006, 1'b0, R_NEVER},
        '{STEP_CMD, '0, T_OP, 16'h0003, 1'b0, R_NEVER}
    };

    logic                          clk;
    logic                          rst_n;
    logic                          cfg_we;
    logic [ecs_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [ecs_pkg::CFG_W-1:0]     cfg_wdata;

    ecs_cmd_if cmd ();
    ecs_rsp_if rsp ();

    engine_crank_sequencer_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .rsp       (rsp),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    // Our own copy of the sequencer: registers, phase, counter, last outcome.
    ecs_pkg::cfg_t                  seq_cfg;
    logic [1:0]                     seq_phase;
    logic [ecs_pkg::TIMER_BITS-1:0] seq_elapsed;
    logic [1:0]                     seq_last;

    // Relay pictures still owed by the core, oldest first.
    ecs_pkg::result_t pending_relays [$];

    // A hand-typed expectation for the beat currently being offered.
    bit               pin_on;
    ecs_pkg::result_t pin_val;

    bit               idle_on;
    int unsigned      cycle_count;
    int unsigned      error_count;

    // Bumps the elapsed counter, saturating at full scale, and tells whether
    // the wait of the given length is over. Full scale always ends a wait.
    function automatic bit tick_wait_done(input logic [ecs_pkg::CFG_W-1:0] limit_ms);
        if (seq_elapsed != ecs_pkg::TIMER_FULL)
            seq_elapsed = seq_elapsed + 1'b1;
        return (ecs_pkg::CMP_W'(seq_elapsed) >= ecs_pkg::CMP_W'(limit_ms)) ||
               (seq_elapsed == ecs_pkg::TIMER_FULL);
    endfunction

    // Applies one command beat to the sequence and returns the relay picture
    // that the core must report for it.
    function automatic ecs_pkg::result_t sequence_step(
        input logic                        op,
        input logic [ecs_pkg::SPEED_W-1:0] speed
    );
        ecs_pkg::result_t r;
        if (op == ecs_pkg::OP_START)
        begin
            if (seq_phase == ecs_pkg::PH_IDLE)
            begin
                seq_phase   = ecs_pkg::PH_PRIME;
                seq_elapsed = '0;
            end
        end
        else
        begin
            case (seq_phase)
                ecs_pkg::PH_PRIME:
                begin
                    if (tick_wait_done(seq_cfg.prime_time_ms))
                    begin
                        seq_phase   = ecs_pkg::PH_CRANK;
                        seq_elapsed = '0;
                    end
                end
                ecs_pkg::PH_CRANK:
                begin
                    // The speed sample wins over the timeout on the same tick.
                    if (speed >= seq_cfg.run_speed_rpm)
                    begin
                        seq_phase   = ecs_pkg::PH_SETTLE;
                        seq_elapsed = '0;
                    end
                    else if (tick_wait_done(seq_cfg.crank_limit_ms))
                    begin
                        seq_phase   = ecs_pkg::PH_IDLE;
                        seq_elapsed = '0;
                        seq_last    = ecs_pkg::OUT_TIMEOUT;
                    end
                end
                ecs_pkg::PH_SETTLE:
                begin
                    if (tick_wait_done(seq_cfg.settle_time_ms))
                    begin
                        seq_phase   = ecs_pkg::PH_IDLE;
                        seq_elapsed = '0;
                        seq_last    = ecs_pkg::OUT_STARTED;
                    end
                end
                default: ;
            endcase
        end

        case (seq_phase)
            ecs_pkg::PH_PRIME:  r = R_PRIME;
            ecs_pkg::PH_CRANK:  r = R_CRANK;
            ecs_pkg::PH_SETTLE: r = R_SETTLE;
            default:
            begin
                // In idle the relays only stay on after a successful start.
                r.ignition_main = (seq_last == ecs_pkg::OUT_STARTED);
                r.ignition_aux  = (seq_last == ecs_pkg::OUT_STARTED);
                r.starter_on    = 1'b0;
                r.outcome       = seq_last;
            end
        endcase
        return r;
    endfunction

    // Engine speed for a tick. Most samples sit just under or just over the
    // run threshold so that cranks both succeed and run out; the rest cover
    // the full range of the field.
    function automatic logic [ecs_pkg::SPEED_W-1:0] pick_speed();
        int unsigned thr;
        int unsigned span;
        thr = seq_cfg.run_speed_rpm;
        case ($urandom_range(9))
            0: return ecs_pkg::SPEED_W'($urandom);
            1: return '0;
            2: return '1;
            3: return (thr + 3 > 16'hFFFF) ? '1 :
                      ecs_pkg::SPEED_W'(thr + $urandom_range(3));
            default:
            begin
                if (thr == 0)
                    return '0;
                span = (thr - 1 > 50) ? 50 : thr - 1;
                return ecs_pkg::SPEED_W'(thr - 1 - $urandom_range(span));
            end
        endcase
    endfunction

    // Time register value: mostly short waits, with the extremes mixed in.
    function automatic logic [ecs_pkg::CFG_W-1:0] pick_ms();
        case ($urandom_range(15))
            0:       return '0;
            1:       return '1;
            2:       return ecs_pkg::CFG_W'($urandom);
            default: return ecs_pkg::CFG_W'($urandom_range(1, 8));
        endcase
    endfunction

    // Clock with a 4 ns period.
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Result sink: ready drops at random with a chance of about 18 percent, except
    // while the no-idle stretch is running.
    initial
    begin
        rsp.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            rsp.ready <= !idle_on || ($urandom_range(99) >= 18);
        end
    end

    // Watchdog on the whole run.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("%0t: run did not finish within %0d cycles", $time, CYCLE_LIMIT);
            $display("engine_crank_sequencer_core_tb NOT OK");
            $finish;
        end
    end

    // Scoreboard. Register writes and accepted command beats update the model
    // at the same edge that the core sees them; a command beat queues its
    // relay picture before the result side is looked at, so the check does
    // not depend on how many cycles the core takes.
    always @(posedge clk)
    begin : scoreboard
        ecs_pkg::result_t predicted;
        ecs_pkg::result_t seen;
        ecs_pkg::result_t want;
        if (!rst_n)
        begin
            seq_cfg     = '{ecs_pkg::PRIME_TIME_RST, ecs_pkg::CRANK_LIMIT_RST,
                            ecs_pkg::SETTLE_TIME_RST, ecs_pkg::RUN_SPEED_RST};
            seq_phase   = ecs_pkg::PH_IDLE;
            seq_elapsed = '0;
            seq_last    = ecs_pkg::OUT_NEVER;
            pending_relays.delete();
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    ecs_pkg::REG_PRIME_TIME:  seq_cfg.prime_time_ms  = cfg_wdata;
                    ecs_pkg::REG_CRANK_LIMIT: seq_cfg.crank_limit_ms = cfg_wdata;
                    ecs_pkg::REG_SETTLE_TIME: seq_cfg.settle_time_ms = cfg_wdata;
                    ecs_pkg::REG_RUN_SPEED:   seq_cfg.run_speed_rpm  = cfg_wdata;
                    default: ;
                endcase
            end

            if (cmd.valid && cmd.ready)
            begin
                predicted = sequence_step(cmd.operation, cmd.engine_speed);
                pending_relays.push_back(pin_on ? pin_val : predicted);
            end

            if (rsp.valid && rsp.ready)
            begin
                seen = '{rsp.ignition_main, rsp.ignition_aux, rsp.starter_on,
                         rsp.outcome};
                if (pending_relays.size() == 0)
                begin
                    error_count++;
                    $display({"%0t: result beat with nothing expected: ",
                              "main=%0b aux=%0b starter=%0b outcome=%0d"},
                             $time, seen.ignition_main, seen.ignition_aux,
                             seen.starter_on, seen.outcome);
                end
                else
                begin
                    want = pending_relays.pop_front();
                    if (seen !== want)
                    begin
                        error_count++;
                        $display({"%0t: relay mismatch: expected main=%0b aux=%0b ",
                                  "starter=%0b outcome=%0d, got main=%0b aux=%0b ",
                                  "starter=%0b outcome=%0d"},
                                 $time, want.ignition_main, want.ignition_aux,
                                 want.starter_on, want.outcome, seen.ignition_main,
                                 seen.ignition_aux, seen.starter_on, seen.outcome);
                    end
                end
            end
        end
    end

    // Offers one command beat and returns at the falling edge after it was
    // taken. All driving happens at falling edges, so each input changes at
    // most once per time step. Valid is left high on return; the next call
    // or a drain decides what it does next.
    task automatic send_command(input logic                        op,
                                input logic [ecs_pkg::SPEED_W-1:0] speed);
        while (idle_on && $urandom_range(99) < 18)
        begin
            cmd.valid <= 1'b0;
            @(negedge clk);
        end
        cmd.valid        <= 1'b1;
        cmd.operation    <= op;
        cmd.engine_speed <= speed;
        do
            @(posedge clk);
        while (!cmd.ready);
        @(negedge clk);
    endtask

    // Stops offering beats and waits until every relay picture owed has come
    // back, then pads with idle falling edges for the result register.
    task automatic wait_quiet();
        cmd.valid <= 1'b0;
        while (pending_relays.size() != 0)
            @(negedge clk);
        repeat (2) @(negedge clk);
    endtask

    // One register write, only issued while the core is quiet.
    task automatic write_register(input logic [ecs_pkg::CFG_IDX_W-1:0] idx,
                                  input logic [ecs_pkg::CFG_W-1:0]     data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(negedge clk);
        cfg_we    <= 1'b0;
        @(negedge clk);
    endtask

    initial
    begin : stimulus
        int   useful;
        logic op;

        rst_n            = 1'b0;
        cmd.valid        = 1'b0;
        cmd.operation    = ecs_pkg::OP_TICK;
        cmd.engine_speed = '0;
        cfg_we           = 1'b0;
        cfg_index        = '0;
        cfg_wdata        = '0;
        pin_on           = 1'b0;
        pin_val          = R_NEVER;
        idle_on          = 1'b1;
        cycle_count      = 0;
        error_count      = 0;

        repeat (6) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed table: corners of every phase and of every register.
        foreach (dir_steps[i])
        begin
            if (dir_steps[i].kind == STEP_CFG)
            begin
                wait_quiet();
                write_register(dir_steps[i].index, dir_steps[i].value);
            end
            else
            begin
                pin_on  = dir_steps[i].pinned;
                pin_val = dir_steps[i].want;
                send_command(dir_steps[i].op, dir_steps[i].value);
                pin_on  = 1'b0;
            end
        end

        // Random phases. Each starts from a quiet core with a fresh register
        // set; a sequence that is still running carries over into the next
        // phase, so new values also land mid-sequence. The first two phases
        // hold a full-scale prime and settle time respectively.
        for (int ph = 0; ph < RAND_PHASES; ph++)
        begin
            wait_quiet();
            idle_on = (ph < 5) || (ph > 7);
            write_register(ecs_pkg::REG_PRIME_TIME,  (ph == 0) ? '1 : pick_ms());
            write_register(ecs_pkg::REG_CRANK_LIMIT, pick_ms());
            write_register(ecs_pkg::REG_SETTLE_TIME, (ph == 1) ? '1 : pick_ms());
            write_register(ecs_pkg::REG_RUN_SPEED,
                           ($urandom_range(7) == 0) ?
                           ($urandom_range(1) ? '1 : '0) :
                           ecs_pkg::CFG_W'($urandom));
            useful = 0;
            while (useful < BEATS_PER_PHASE)
            begin
                // Now and then hold the sender until the core has caught up.
                if ($urandom_range(39) == 0)
                    wait_quiet();
                // Mostly well-formed traffic: starts from idle and ticks while
                // a sequence runs, with stray starts and idle ticks as noise.
                if (seq_phase == ecs_pkg::PH_IDLE)
                    op = ($urandom_range(4) != 0) ? ecs_pkg::OP_START : ecs_pkg::OP_TICK;
                else
                    op = ($urandom_range(19) == 0) ? ecs_pkg::OP_START : ecs_pkg::OP_TICK;
                if ((op == ecs_pkg::OP_START) == (seq_phase == ecs_pkg::PH_IDLE))
                    useful++;
                send_command(op, pick_speed());
            end
        end

        wait_quiet();
        repeat (4) @(negedge clk);

        if (error_count == 0)
            $display("engine_crank_sequencer_core_tb OK");
        else
            $display("engine_crank_sequencer_core_tb NOT OK");
        $finish;
    end

endmodule

FILE: files.f
design/ecs_pkg.sv
design/ecs_if.sv
design/ecs_cfg_regs.sv
design/ecs_seq.sv
design/ecs_out_stage.sv
design/engine_crank_sequencer_core.sv
design/ecs_checker.sv
dv/engine_crank_sequencer_core_tb.sv
